[src/wfpd_pkg.sv]
// Shared types and constants for the wall-follow PD steering unit.
// No dependencies; imported by every module of the block.
package wfpd_pkg;

  localparam int DistW = 12;
  localparam int ErrW  = 13;
  localparam int DeltaW = 14;
  localparam int KpW   = 10;
  localparam int KdW   = 12;
  localparam int CmdW  = 32;
  localparam int CfgIdxW = 3;

  // Bound on the sum of both diagonals for centering between two walls.
  localparam logic [DistW:0] BOTH_WALL_SUM_MAX = (DistW + 1)'(300);

  typedef enum logic [CfgIdxW-1:0] {
    REG_FOLLOW_MIN  = 3'd0,
    REG_FOLLOW_MAX  = 3'd1,
    REG_ALIGN_MIN   = 3'd2,
    REG_ALIGN_MAX   = 3'd3,
    REG_SIDE_TARGET = 3'd4,
    REG_SUCCESS_GAP = 3'd5,
    REG_GAIN_P      = 3'd6,
    REG_GAIN_D      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [DistW-1:0] follow_min_dist;
    logic [DistW-1:0] follow_max_dist;
    logic [DistW-1:0] align_min_dist;
    logic [DistW-1:0] align_max_dist;
    logic [DistW-1:0] side_target_dist;
    logic [DistW-1:0] success_gap;
    logic [KpW-1:0]   gain_proportional;
    logic [KdW-1:0]   gain_derivative;
  } cfg_t;

  typedef struct packed {
    logic             follow_enable;
    logic             wall_front;
    logic             wall_left;
    logic             wall_right;
    logic [DistW-1:0] dist_front_left;
    logic [DistW-1:0] dist_front_right;
    logic [DistW-1:0] dist_diag_left;
    logic [DistW-1:0] dist_diag_right;
  } sensor_t;

  typedef struct packed {
    logic signed [ErrW-1:0]   err;
    logic signed [DeltaW-1:0] delta;
    logic                     success;
  } err_t;

  function automatic logic in_open_range(input logic [DistW-1:0] v,
                                         input logic [DistW-1:0] lo,
                                         input logic [DistW-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

endpackage

[src/wfpd_cfg_regs.sv]
// Configuration register file of the wall-follow PD steering unit.
// Depends on wfpd_pkg for the register index codes and the cfg_t bundle.
module wfpd_cfg_regs import wfpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DistW-1:0]   cfg_data,
  output cfg_t               cfg
);

  cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.follow_min_dist   <= '0;
      regs.follow_max_dist   <= DistW'(4095);
      regs.align_min_dist    <= '0;
      regs.align_max_dist    <= DistW'(4095);
      regs.side_target_dist  <= '0;
      regs.success_gap       <= '0;
      regs.gain_proportional <= KpW'(8);
      regs.gain_derivative   <= KdW'(800);
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_FOLLOW_MIN:  regs.follow_min_dist   <= cfg_data;
        REG_FOLLOW_MAX:  regs.follow_max_dist   <= cfg_data;
        REG_ALIGN_MIN:   regs.align_min_dist    <= cfg_data;
        REG_ALIGN_MAX:   regs.align_max_dist    <= cfg_data;
        REG_SIDE_TARGET: regs.side_target_dist  <= cfg_data;
        REG_SUCCESS_GAP: regs.success_gap       <= cfg_data;
        REG_GAIN_P:      regs.gain_proportional <= cfg_data[KpW-1:0];
        REG_GAIN_D:      regs.gain_derivative   <= cfg_data[KdW-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/wfpd_error_select.sv]
// Error selection stage: priority rules, held error and success latch.
// Depends on wfpd_pkg; registers err_t for the PD stage.
module wfpd_error_select import wfpd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    up_valid,
  output logic    up_stall,
  input  sensor_t sensor,
  output logic    dn_valid,
  input  logic    dn_stall,
  output err_t    dn_data
);

  // held_error also serves as the previous error: both take e every tick.
  logic signed [ErrW-1:0] held_error;
  logic signed [ErrW-1:0] held_error_next;
  logic                   success_latch;
  logic                   success_latch_next;
  logic                   load;

  logic                   take;
  logic signed [ErrW-1:0] cand;
  logic [ErrW-1:0]        cand_mag;
  logic                   front_ok;
  logic                   diag_l_ok;
  logic                   diag_r_ok;
  logic [DistW:0]         diag_sum;

  assign up_stall = dn_valid && dn_stall;
  assign load     = up_valid && !up_stall;

  always_comb begin
    front_ok  = in_open_range(sensor.dist_front_left, cfg.align_min_dist, cfg.align_max_dist) &&
                in_open_range(sensor.dist_front_right, cfg.align_min_dist, cfg.align_max_dist);
    diag_l_ok = in_open_range(sensor.dist_diag_left, cfg.follow_min_dist, cfg.follow_max_dist);
    diag_r_ok = in_open_range(sensor.dist_diag_right, cfg.follow_min_dist,
                              cfg.follow_max_dist);
    diag_sum  = {1'b0, sensor.dist_diag_left} + {1'b0, sensor.dist_diag_right};
    take = 1'b0;
    cand = '0;
    if (sensor.wall_front) begin
      // right wall wins; an out-of-range right diagonal holds the error
      cand = $signed({1'b0, sensor.dist_front_left}) - $signed({1'b0, sensor.dist_front_right});
      if (sensor.wall_right) begin
        take = diag_r_ok && front_ok;
      end else if (sensor.wall_left) begin
        take = diag_l_ok && front_ok;
      end
    end else if (sensor.wall_left && sensor.wall_right) begin
      cand = $signed({1'b0, sensor.dist_diag_right}) - $signed({1'b0, sensor.dist_diag_left});
      take = diag_sum < BOTH_WALL_SUM_MAX;
    end else if (sensor.wall_left) begin
      cand = $signed({1'b0, cfg.side_target_dist}) - $signed({1'b0, sensor.dist_diag_left});
      take = diag_l_ok;
    end else if (sensor.wall_right) begin
      cand = $signed({1'b0, sensor.dist_diag_right}) - $signed({1'b0, cfg.side_target_dist});
      take = diag_r_ok;
    end
    cand_mag = cand[ErrW-1] ? ErrW'(-cand) : ErrW'(cand);

    held_error_next    = held_error;
    success_latch_next = success_latch;
    if (!sensor.follow_enable) begin
      held_error_next = '0;
    end else if (take) begin
      held_error_next = cand;
      if (cand_mag < {1'b0, cfg.success_gap}) begin
        success_latch_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_error    <= '0;
      success_latch <= 1'b0;
      dn_valid      <= 1'b0;
    end else begin
      if (load) begin
        held_error    <= held_error_next;
        success_latch <= success_latch_next;
        dn_valid      <= 1'b1;
      end else if (!dn_stall) begin
        dn_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dn_data.err     <= held_error_next;
      dn_data.delta   <= DeltaW'(held_error_next) - DeltaW'(held_error);
      dn_data.success <= success_latch_next;
    end
  end

endmodule

[src/wfpd_pd_law.sv]
// PD law stage: kp*e + kd*(e - e_prev) into the result register.
// Depends on wfpd_pkg for err_t and the field widths.
module wfpd_pd_law import wfpd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   up_valid,
  output logic                   up_stall,
  input  err_t                   up_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [CmdW-1:0] steer_command,
  output logic signed [ErrW-1:0] steer_error,
  output logic                   success_flag
);

  localparam int PTermW = KpW + 1 + ErrW;
  localparam int DTermW = KdW + 1 + DeltaW;
  localparam int SumW   = DTermW + 1;

  logic                     load;
  logic signed [PTermW-1:0] p_term;
  logic signed [DTermW-1:0] d_term;
  logic signed [SumW-1:0]   cmd_sum;

  assign up_stall = out_valid && out_stall;
  assign load     = up_valid && !up_stall;

  // Both products and their 28-bit sum fit inside 32 bits, so no clamp is needed.
  always_comb begin
    p_term  = $signed({1'b0, cfg.gain_proportional}) * up_data.err;
    d_term  = $signed({1'b0, cfg.gain_derivative}) * up_data.delta;
    cmd_sum = SumW'(p_term) + SumW'(d_term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      steer_command <= CmdW'(cmd_sum);
      steer_error   <= up_data.err;
      success_flag  <= up_data.success;
    end
  end

endmodule

[src/wall_follow_pd_steering_unit.sv]
// Top level of the wall-follow PD steering unit.
// Depends on wfpd_pkg, wfpd_cfg_regs, wfpd_error_select and wfpd_pd_law.
//
// One sensor tick enters on the input channel (in_valid / in_stall) with the
// enable flag, wall flags and four distances; one result leaves on the output
// channel (out_valid / out_stall) with the PD command, the error used and the
// success flag. A transfer happens on a clock edge with valid high, stall low.
// Pipeline: input register, error selection register, result register.
// A tick passes through these registers in that order; out_valid rises when the
// result register loads, and throughput is one tick per cycle while out_stall
// stays low. Each stage moves on when the stage after it is empty or moving,
// so a new tick is taken while a finished result still waits.
// When the receiver stalls, results and payloads hold and the stall ripples
// back stage by stage; in_stall rises once all three registers are full.
// Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are
// always taken (cfg_ready is high); indexes follow the register list order.
// Reset (rst, synchronous) empties the pipeline, clears the held error and
// success latch, and loads the register defaults.
module wall_follow_pd_steering_unit import wfpd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   follow_enable,
  input  logic                   wall_front,
  input  logic                   wall_left,
  input  logic                   wall_right,
  input  logic [DistW-1:0]       dist_front_left,
  input  logic [DistW-1:0]       dist_front_right,
  input  logic [DistW-1:0]       dist_diag_left,
  input  logic [DistW-1:0]       dist_diag_right,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [CmdW-1:0] steer_command,
  output logic signed [ErrW-1:0] steer_error,
  output logic                   success_flag,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [DistW-1:0]       cfg_data
);

  cfg_t    cfg;
  sensor_t in_reg;
  logic    in_reg_valid;
  logic    sel_stall;
  logic    err_valid;
  logic    err_stall;
  err_t    err_data;
  logic    load;

  wfpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_stall = in_reg_valid && sel_stall;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (load) begin
      in_reg_valid <= 1'b1;
    end else if (!sel_stall) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_reg.follow_enable    <= follow_enable;
      in_reg.wall_front       <= wall_front;
      in_reg.wall_left        <= wall_left;
      in_reg.wall_right       <= wall_right;
      in_reg.dist_front_left  <= dist_front_left;
      in_reg.dist_front_right <= dist_front_right;
      in_reg.dist_diag_left   <= dist_diag_left;
      in_reg.dist_diag_right  <= dist_diag_right;
    end
  end

  wfpd_error_select u_sel (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (in_reg_valid),
    .up_stall (sel_stall),
    .sensor   (in_reg),
    .dn_valid (err_valid),
    .dn_stall (err_stall),
    .dn_data  (err_data)
  );

  wfpd_pd_law u_pd (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .up_valid      (err_valid),
    .up_stall      (err_stall),
    .up_data       (err_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .steer_command (steer_command),
    .steer_error   (steer_error),
    .success_flag  (success_flag)
  );

endmodule
